>>> rtl/core/cpgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpgd_pkg
// Shared types and constants of the coin pulse group decoder.
// ----------------------------------------------------------------------------
package cpgd_pkg;

  localparam int          MAX_DENOMS       = 4;
  localparam logic [7:0]  MAX_GROUP_PULSES = 8'd32;
  localparam logic [9:0]  MS_PER_S         = 10'd1000;
  localparam logic [15:0] FALLBACK_IDLE_S  = 16'd300;
  localparam int          IDLE_LIMIT_W     = 26;
  localparam int          DENOM_N_W        = 3;
  localparam int          CFG_INDEX_W      = 3;
  localparam int          CFG_DATA_W       = 64;

  // reset values of the configuration registers
  localparam logic [15:0] RST_DEBOUNCE_MS  = 16'd30;
  localparam logic [15:0] RST_SETTLE_MS    = 16'd150;
  localparam logic [15:0] RST_GUARD_MS     = 16'd100;
  localparam logic [63:0] RST_DENOM_TABLE  = 64'h1414_0A0A_0505_0101;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_DEBOUNCE = 3'd1,
    REG_SETTLE   = 3'd2,
    REG_GUARD    = 3'd3,
    REG_IDLE     = 3'd4,
    REG_DENOM_N  = 3'd5,
    REG_TABLE    = 3'd6
  } reg_idx_t;

  // classified request kinds carried through the queue
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_EDGE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_COIN  = 2'd1,
    EV_OVER  = 2'd2,
    EV_UNSUP = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    ACT_DISABLED = 2'd0,
    ACT_WAITING  = 2'd1,
    ACT_ACTIVE   = 2'd2,
    ACT_IDLE     = 2'd3
  } act_t;

  // configuration as seen by the back end
  typedef struct packed {
    logic                    enable;
    logic [15:0]             debounce_ms;
    logic [15:0]             settle_ms;
    logic [15:0]             guard_ms;
    logic [IDLE_LIMIT_W-1:0] idle_limit_ms;
    logic [DENOM_N_W-1:0]    denom_n;
    logic [63:0]             denom_table;
  } cfg_t;

  // head of the request queue
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

endpackage

>>> rtl/core/coin_pulse_group_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coin_pulse_group_decoder
// Decode groups of coin-slot pulses into accepted coins and errors.
// ----------------------------------------------------------------------------
// Each request is one millisecond tick (command 0, with pin_edge set when a
// falling edge was seen) or a clear of the counters (command 1), and each
// request gives exactly one result carrying the event of that tick, the
// activity state and the three running counters. A new request is taken on
// every clock while the request queue has room: the front end classifies
// requests into a two-entry queue, and the back end updates the whole
// decoder state for each request and holds the result in an
// output register, so the sustained rate is one request per cycle while
// out_stall is low. An accepted request waits in the queue; the back end
// then carries it out and registers its result. in_stall rises only when
// the queue is full, which happens only while out_stall holds the back end. The
// configuration registers are written through the cfg channel, which is
// always ready; write them only while no request is in flight. The idle
// timeout is turned into milliseconds when it is written, so the idle
// compare needs no multiplier in the request path. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module coin_pulse_group_decoder import cpgd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   command,
  input  logic                   pin_edge,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             event_res,
  output logic [7:0]             group_pulses,
  output logic [7:0]             pesos,
  output logic [1:0]             activity,
  output logic [31:0]            total_pulses,
  output logic [31:0]            total_coins,
  output logic [31:0]            error_count,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  q_head_t q_head;
  logic    q_pop;

  logic                    enable;
  logic [15:0]             debounce_ms;
  logic [15:0]             settle_ms;
  logic [15:0]             guard_ms;
  logic [IDLE_LIMIT_W-1:0] idle_limit_ms;
  logic [DENOM_N_W-1:0]    denom_n;
  logic [63:0]             denom_table;

  logic                    cfg_write;
  logic [15:0]             idle_secs;
  logic [IDLE_LIMIT_W-1:0] idle_limit_wr;
  logic [DENOM_N_W-1:0]    denom_n_wr;

  // writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // a zero timeout falls back to the default; convert to ms once, here
  assign idle_secs     = (cfg_data[15:0] == 16'd0) ? FALLBACK_IDLE_S : cfg_data[15:0];
  assign idle_limit_wr = {{(IDLE_LIMIT_W-16){1'b0}}, idle_secs} *
                         {{(IDLE_LIMIT_W-10){1'b0}}, MS_PER_S};

  // clip the table length to the table size; zero stays zero and matches nothing
  assign denom_n_wr = (cfg_data[DENOM_N_W-1:0] > DENOM_N_W'(MAX_DENOMS)) ?
                      DENOM_N_W'(MAX_DENOMS) : cfg_data[DENOM_N_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b1;
      debounce_ms   <= RST_DEBOUNCE_MS;
      settle_ms     <= RST_SETTLE_MS;
      guard_ms      <= RST_GUARD_MS;
      idle_limit_ms <= {{(IDLE_LIMIT_W-16){1'b0}}, FALLBACK_IDLE_S} *
                       {{(IDLE_LIMIT_W-10){1'b0}}, MS_PER_S};
      denom_n       <= DENOM_N_W'(MAX_DENOMS);
      denom_table   <= RST_DENOM_TABLE;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ENABLE:   enable        <= cfg_data[0];
        REG_DEBOUNCE: debounce_ms   <= cfg_data[15:0];
        REG_SETTLE:   settle_ms     <= cfg_data[15:0];
        REG_GUARD:    guard_ms      <= cfg_data[15:0];
        REG_IDLE:     idle_limit_ms <= idle_limit_wr;
        REG_DENOM_N:  denom_n       <= denom_n_wr;
        REG_TABLE:    denom_table   <= cfg_data;
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  always_comb begin
    cfg.enable        = enable;
    cfg.debounce_ms   = debounce_ms;
    cfg.settle_ms     = settle_ms;
    cfg.guard_ms      = guard_ms;
    cfg.idle_limit_ms = idle_limit_ms;
    cfg.denom_n       = denom_n;
    cfg.denom_table   = denom_table;
  end

  // front end: accept and classify requests, queue them
  cpgd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .pin_edge (pin_edge),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // back end: advance the decoder state and hold the result
  cpgd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .group_pulses (group_pulses),
    .pesos        (pesos),
    .activity     (activity),
    .total_pulses (total_pulses),
    .total_coins  (total_coins),
    .error_count  (error_count)
  );

endmodule

>>> rtl/core/cpgd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpgd_front
// Accept input requests, classify them and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module cpgd_front import cpgd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    command,
  input  logic    pin_edge,
  output q_head_t q_head,
  input  logic    q_pop
);

  op_t        entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       push;
  logic       pop;
  op_t        op_in;

  always_comb begin
    priority if (command) begin
      op_in = OP_CLEAR;
    end else if (pin_edge) begin
      op_in = OP_EDGE;
    end else begin
      op_in = OP_TICK;
    end
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && (count != 2'd0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= op_in;
    end
  end

  assign q_head.valid = (count != 2'd0);
  assign q_head.op    = entry[rd_ptr];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count beyond depth");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> count != 2'd0)
    else $error("accepted request missing from queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + 2'd1 ||
                     count + 2'd1 == $past(count)))
    else $error("queue count jumped");

endmodule

>>> rtl/core/cpgd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpgd_back
// Carry out one queued request per cycle while the output is not stalled, and register the result.
// ----------------------------------------------------------------------------
module cpgd_back import cpgd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  q_head_t     q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [7:0]  group_pulses,
  output logic [7:0]  pesos,
  output logic [1:0]  activity,
  output logic [31:0] total_pulses,
  output logic [31:0] total_coins,
  output logic [31:0] error_count
);

  logic [31:0] now_ms,         now_ms_next;
  logic [31:0] last_edge_ms,   last_edge_ms_next;
  logic [31:0] last_closed_ms, last_closed_ms_next;
  logic [31:0] guard_until_ms, guard_until_ms_next;
  logic [31:0] last_coin_ms,   last_coin_ms_next;
  logic [7:0]  pending_pulses, pending_pulses_next;
  logic [31:0] pulse_total,    pulse_total_next;
  logic [31:0] coin_total,     coin_total_next;
  logic [31:0] reject_total,   reject_total_next;

  logic        step;
  logic [31:0] tick_ms;
  logic [31:0] guard_diff;
  logic [31:0] edge_diff;
  logic [15:0] db_eff;
  logic        counted;
  logic        closing;
  logic        hit;
  logic [7:0]  hit_pesos;
  ev_t         ev_next;
  logic [7:0]  grp_next;
  logic [7:0]  pesos_next;
  act_t        act_next;
  logic [31:0] last_seen;
  logic [31:0] quiet_ms;

  assign step  = q_head.valid && (!out_valid || !out_stall);
  assign q_pop = step;

  assign tick_ms    = now_ms + 32'd1;
  assign guard_diff = tick_ms - guard_until_ms;
  assign edge_diff  = tick_ms - last_edge_ms;
  assign db_eff     = (cfg.debounce_ms == 16'd0) ? 16'd1 : cfg.debounce_ms;

  assign counted = (q_head.op == OP_EDGE) && cfg.enable && !guard_diff[31] &&
                   (edge_diff >= {16'd0, db_eff});
  // a counted edge resets the quiet time, so it can never close in the same tick
  assign closing = (q_head.op != OP_CLEAR) && cfg.enable && !counted &&
                   (pending_pulses != 8'd0) && (edge_diff > {16'd0, cfg.settle_ms}) &&
                   (last_edge_ms != last_closed_ms);

  // first table entry whose pulse count matches wins
  always_comb begin
    hit       = 1'b0;
    hit_pesos = 8'd0;
    for (int i = 0; i < MAX_DENOMS; i++) begin
      if (!hit && (DENOM_N_W'(i) < cfg.denom_n) &&
          (cfg.denom_table[16*i +: 8] == pending_pulses)) begin
        hit       = 1'b1;
        hit_pesos = cfg.denom_table[16*i+8 +: 8];
      end
    end
  end

  always_comb begin
    now_ms_next         = now_ms;
    last_edge_ms_next   = last_edge_ms;
    last_closed_ms_next = last_closed_ms;
    guard_until_ms_next = guard_until_ms;
    last_coin_ms_next   = last_coin_ms;
    pending_pulses_next = pending_pulses;
    pulse_total_next    = pulse_total;
    coin_total_next     = coin_total;
    reject_total_next   = reject_total;
    ev_next             = EV_NONE;
    grp_next            = 8'd0;
    pesos_next          = 8'd0;
    if (q_head.op == OP_CLEAR) begin
      pending_pulses_next = 8'd0;
      last_closed_ms_next = 32'd0;
      last_coin_ms_next   = 32'd0;
      pulse_total_next    = 32'd0;
      coin_total_next     = 32'd0;
      reject_total_next   = 32'd0;
    end else begin
      now_ms_next = tick_ms;
      if (counted) begin
        last_edge_ms_next = tick_ms;
        if (pending_pulses != 8'hFF) begin
          pending_pulses_next = pending_pulses + 8'd1;
        end
        pulse_total_next = pulse_total + 32'd1;
      end
      if (closing) begin
        grp_next            = pending_pulses;
        pending_pulses_next = 8'd0;
        last_closed_ms_next = last_edge_ms;
        guard_until_ms_next = tick_ms + {16'd0, cfg.guard_ms};
        if (pending_pulses > MAX_GROUP_PULSES) begin
          ev_next           = EV_OVER;
          reject_total_next = reject_total + 32'd1;
        end else if (hit) begin
          ev_next           = EV_COIN;
          pesos_next        = hit_pesos;
          coin_total_next   = coin_total + 32'd1;
          last_coin_ms_next = tick_ms;
        end else begin
          ev_next           = EV_UNSUP;
          reject_total_next = reject_total + 32'd1;
        end
      end
    end
  end

  assign last_seen = (last_edge_ms_next > last_coin_ms_next) ? last_edge_ms_next
                                                              : last_coin_ms_next;
  assign quiet_ms  = now_ms_next - last_seen;

  always_comb begin
    priority if (!cfg.enable) begin
      act_next = ACT_DISABLED;
    end else if (pulse_total_next == 32'd0) begin
      act_next = ACT_WAITING;
    end else if ((last_seen != 32'd0) &&
                 (quiet_ms >= {{(32-IDLE_LIMIT_W){1'b0}}, cfg.idle_limit_ms})) begin
      act_next = ACT_IDLE;
    end else begin
      act_next = ACT_ACTIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms         <= 32'd0;
      last_edge_ms   <= 32'd0;
      last_closed_ms <= 32'd0;
      guard_until_ms <= 32'd0;
      last_coin_ms   <= 32'd0;
      pending_pulses <= 8'd0;
      pulse_total    <= 32'd0;
      coin_total     <= 32'd0;
      reject_total   <= 32'd0;
      out_valid      <= 1'b0;
    end else begin
      if (step) begin
        now_ms         <= now_ms_next;
        last_edge_ms   <= last_edge_ms_next;
        last_closed_ms <= last_closed_ms_next;
        guard_until_ms <= guard_until_ms_next;
        last_coin_ms   <= last_coin_ms_next;
        pending_pulses <= pending_pulses_next;
        pulse_total    <= pulse_total_next;
        coin_total     <= coin_total_next;
        reject_total   <= reject_total_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_res    <= ev_next;
      group_pulses <= grp_next;
      pesos        <= pesos_next;
      activity     <= act_next;
      total_pulses <= pulse_total_next;
      total_coins  <= coin_total_next;
      error_count  <= reject_total_next;
    end
  end

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_NONE) |-> (group_pulses == 8'd0))
    else $error("group count without a closed group");

  a_pesos_coin: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res != EV_COIN) |-> (pesos == 8'd0))
    else $error("pesos without an accepted coin");

  a_over_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_OVER) |-> (group_pulses > MAX_GROUP_PULSES))
    else $error("over-limit event on a short group");

  a_coin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_COIN) |->
      (group_pulses != 8'd0) && (group_pulses <= MAX_GROUP_PULSES))
    else $error("coin from a group out of range");

endmodule

>>> test/tb_coin_pulse_group_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coin_pulse_group_decoder
// Self-checking bench for the coin pulse group decoder.
// ----------------------------------------------------------------------------
// A behavioural model of the decoder runs beside the RTL, stepped at every
// accepted request and every configuration write. Each result is compared
// field by field with the oldest predicted one. Stimulus is a short directed
// sweep (power-on, table lookup, clear, disable, timing extremes) followed by random
// coin pulse trains with bounce and guard-window noise, long trains that go
// over the group limit and saturate the group counter, an idle timeout run,
// free-running noise and a maximum guard window. Both handshakes idle and
// stall at random, with one calm stretch and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_coin_pulse_group_decoder;
  import cpgd_pkg::*;

  localparam int          CYCLE_LIMIT   = 300000;
  localparam int          DRAIN_GAP     = 4;
  localparam int          HOLDOFF_TICKS = 200;
  localparam logic [15:0] IDLE_RESET_S  = 16'd300;

  typedef struct packed {
    ev_t         ev;
    logic [7:0]  grp;
    logic [7:0]  pesos;
    act_t        act;
    logic [31:0] pulses;
    logic [31:0] coins;
    logic [31:0] errors;
  } tally_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  logic                   command;
  logic                   pin_edge;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [1:0]             event_res;
  logic [7:0]             group_pulses;
  logic [7:0]             pesos;
  logic [1:0]             activity;
  logic [31:0]            total_pulses;
  logic [31:0]            total_coins;
  logic [31:0]            error_count;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // model copy of the configuration
  logic        en_cfg;
  logic [15:0] debounce_cfg, settle_cfg, guard_cfg, idle_cfg;
  logic [2:0]  count_cfg;
  logic [63:0] table_cfg;

  // model copy of the decoder state
  logic [31:0] now_tick, edge_at, closed_at, guard_until, coin_at;
  logic [7:0]  pend;
  logic [31:0] pulse_cnt, coin_cnt, reject_cnt;

  tally_t owed_results[$];
  int     mismatch_count = 0;
  int     sent_requests  = 0;
  int     cycle_count    = 0;
  bit     calm           = 1'b0;
  int     holdoff_req    = 0;
  int     holdoff_seen   = 0;
  int     holdoff_left   = 0;

  coin_pulse_group_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .pin_edge     (pin_edge),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .group_pulses (group_pulses),
    .pesos        (pesos),
    .activity     (activity),
    .total_pulses (total_pulses),
    .total_coins  (total_coins),
    .error_count  (error_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_coin_pulse_group_decoder: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Behavioural model
  // --------------------------------------------------------------------------
  function automatic void reset_model();
    en_cfg       = 1'b1;
    debounce_cfg = RST_DEBOUNCE_MS;
    settle_cfg   = RST_SETTLE_MS;
    guard_cfg    = RST_GUARD_MS;
    idle_cfg     = IDLE_RESET_S;
    count_cfg    = 3'(MAX_DENOMS);
    table_cfg    = RST_DENOM_TABLE;
    now_tick     = '0;
    edge_at      = '0;
    closed_at    = '0;
    guard_until  = '0;
    coin_at      = '0;
    pend         = '0;
    pulse_cnt    = '0;
    coin_cnt     = '0;
    reject_cnt   = '0;
  endfunction

  function automatic void apply_reg(input reg_idx_t idx, input logic [63:0] data);
    case (idx)
      REG_ENABLE:   en_cfg       = data[0];
      REG_DEBOUNCE: debounce_cfg = data[15:0];
      REG_SETTLE:   settle_cfg   = data[15:0];
      REG_GUARD:    guard_cfg    = data[15:0];
      REG_IDLE:     idle_cfg     = data[15:0];
      REG_DENOM_N:  count_cfg    = data[2:0];
      REG_TABLE:    table_cfg    = data;
      default: ;
    endcase
  endfunction

  // Advance the model by one request and work out the result it owes.
  function automatic void decode_request(input logic clr, input logic pin, output tally_t r);
    logic [31:0] db, span, limit, last;
    logic [15:0] entry;
    int unsigned n;
    logic        hit;
    r = '0;
    if (clr) begin
      // counters and group go, timestamps that gate edges stay
      pend       = '0;
      closed_at  = '0;
      coin_at    = '0;
      pulse_cnt  = '0;
      coin_cnt   = '0;
      reject_cnt = '0;
    end else begin
      now_tick = now_tick + 32'd1;
      if (en_cfg) begin
        if (pin) begin
          db   = (debounce_cfg == 16'd0) ? 32'd1 : {16'd0, debounce_cfg};
          span = now_tick - guard_until;
          if (!span[31] && (now_tick - edge_at) >= db) begin
            edge_at = now_tick;
            if (pend != 8'hFF) pend = pend + 8'd1;
            pulse_cnt = pulse_cnt + 32'd1;
          end
        end
        if (pend != 8'd0 && (now_tick - edge_at) > {16'd0, settle_cfg} &&
            edge_at != closed_at) begin
          r.grp       = pend;
          pend        = '0;
          closed_at   = edge_at;
          guard_until = now_tick + {16'd0, guard_cfg};
          if (r.grp > MAX_GROUP_PULSES) begin
            r.ev       = EV_OVER;
            reject_cnt = reject_cnt + 32'd1;
          end else begin
            n   = (count_cfg > MAX_DENOMS) ? MAX_DENOMS : count_cfg;
            hit = 1'b0;
            for (int i = 0; i < MAX_DENOMS; i++) begin
              entry = table_cfg[16*i +: 16];
              if (!hit && i < n && entry[7:0] == r.grp) begin
                hit     = 1'b1;
                r.pesos = entry[15:8];
              end
            end
            if (hit) begin
              r.ev     = EV_COIN;
              coin_cnt = coin_cnt + 32'd1;
              coin_at  = now_tick;
            end else begin
              r.ev       = EV_UNSUP;
              reject_cnt = reject_cnt + 32'd1;
            end
          end
        end
      end
    end
    if (!en_cfg) begin
      r.act = ACT_DISABLED;
    end else if (pulse_cnt == 32'd0) begin
      r.act = ACT_WAITING;
    end else begin
      limit = ((idle_cfg == 16'd0) ? 32'(FALLBACK_IDLE_S) : 32'(idle_cfg)) * 32'(MS_PER_S);
      last  = (edge_at > coin_at) ? edge_at : coin_at;
      r.act = (last != 32'd0 && (now_tick - last) >= limit) ? ACT_IDLE : ACT_ACTIVE;
    end
    r.pulses = pulse_cnt;
    r.coins  = coin_cnt;
    r.errors = reject_cnt;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Model stepping and result checking, all on the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : score_results
    tally_t want;
    if (rst) begin
      reset_model();
      owed_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(reg_idx_t'(cfg_index), cfg_data);
      // check before predicting, so a same-edge request can never be matched
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          mismatch_count++;
          $display("%0t unexpected result: event %0d, pulses %0d", $time, event_res,
                   group_pulses);
        end else begin
          want = owed_results.pop_front();
          check_field("event_res",    32'(want.ev),    32'(event_res));
          check_field("group_pulses", 32'(want.grp),   32'(group_pulses));
          check_field("pesos",        32'(want.pesos), 32'(pesos));
          check_field("activity",     32'(want.act),   32'(activity));
          check_field("total_pulses", want.pulses,     total_pulses);
          check_field("total_coins",  want.coins,      total_coins);
          check_field("error_count",  want.errors,     error_count);
        end
      end
      if (in_valid && !in_stall) begin
        decode_request(command, pin_edge, want);
        owed_results.push_back(want);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, none while calm, and a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_TICKS;
    end
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left--;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 30);
    end
  end

  // --------------------------------------------------------------------------
  // Sender and configuration helpers
  // --------------------------------------------------------------------------
  // Offer one request; hold it until the block takes it.
  task automatic offer_request(input logic clr, input logic pin);
    int unsigned pause;
    pause = 0;
    if (!calm && $urandom_range(99) < 30) pause = $urandom_range(1, 2);
    @(negedge clk);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= clr;
    pin_edge <= pin;
    do @(posedge clk); while (in_stall);
    sent_requests++;
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input logic en, input logic [15:0] deb, input logic [15:0] st,
                                input logic [15:0] gd, input logic [15:0] idle,
                                input logic [2:0] cnt, input logic [63:0] tbl);
    drain_results();
    write_reg(REG_ENABLE,   64'(en));
    write_reg(REG_DEBOUNCE, 64'(deb));
    write_reg(REG_SETTLE,   64'(st));
    write_reg(REG_GUARD,    64'(gd));
    write_reg(REG_IDLE,     64'(idle));
    write_reg(REG_DENOM_N,  64'(cnt));
    write_reg(REG_TABLE,    tbl);
  endtask

  // Mostly short pulse counts so the trains stay brief; sometimes pure noise.
  function automatic logic [63:0] random_table();
    logic [63:0] t;
    if ($urandom_range(99) < 15) return {$urandom, $urandom};
    for (int i = 0; i < MAX_DENOMS; i++)
      t[16*i +: 16] = {8'($urandom), 8'($urandom_range(1, 12))};
    return t;
  endfunction

  // Favour counts that the table knows, so most groups become coins.
  function automatic int unsigned pick_pulses();
    logic [15:0] entry;
    entry = table_cfg[16*$urandom_range(0, MAX_DENOMS - 1) +: 16];
    if ($urandom_range(99) < 70 && entry[7:0] != 8'd0 && entry[7:0] <= 8'd12)
      return entry[7:0];
    return $urandom_range(1, 12);
  endfunction

  // One coin: pulses spaced by the debounce with a little bounce in between,
  // quiet until the group closes, then edges sprinkled over the guard window.
  task automatic send_coin(input int unsigned pulses);
    int unsigned space, tail;
    for (int unsigned p = 0; p < pulses; p++) begin
      offer_request(1'b0, 1'b1);
      space = ((debounce_cfg == 16'd0) ? 0 : debounce_cfg - 1) + $urandom_range(0, 1);
      repeat (space) offer_request(1'b0, $urandom_range(99) < 10);
    end
    tail = settle_cfg + 1 + $urandom_range(0, 2);
    repeat (tail) offer_request(1'b0, 1'b0);
    tail = guard_cfg + $urandom_range(0, 2);
    repeat (tail) offer_request(1'b0, $urandom_range(99) < 20);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Out of reset the first edges fall inside the debounce from time zero.
  task automatic test_power_on();
    offer_request(1'b0, 1'b1);
    offer_request(1'b0, 1'b0);
    offer_request(1'b1, 1'b1);
    offer_request(1'b0, 1'b1);
  endtask

  // Zero debounce and zero settle: back-to-back edges build a group and the
  // first tick without one closes it. The table has a duplicate pulse count
  // (first entry wins) and an entry worth zero pesos.
  task automatic test_table_lookup();
    apply_settings(1'b1, 16'd0, 16'd0, 16'd0, 16'd65535, 3'd4, 64'h0003_7702_0502_FF01);
    repeat (2) offer_request(1'b0, 1'b1);
    offer_request(1'b0, 1'b0);
    repeat (3) offer_request(1'b0, 1'b1);
    offer_request(1'b0, 1'b0);
    repeat (5) offer_request(1'b0, 1'b1);
    offer_request(1'b0, 1'b0);
  endtask

  // Clear drops the pending group and counters; disabled ignores edges.
  task automatic test_clear_and_disable();
    offer_request(1'b0, 1'b1);
    offer_request(1'b1, 1'b1);
    drain_results();
    write_reg(REG_ENABLE, 64'd0);
    offer_request(1'b0, 1'b1);
    offer_request(1'b0, 1'b0);
    drain_results();
    write_reg(REG_ENABLE, 64'd1);
  endtask

  // Widest debounce and settle, fallback idle timeout, table count above range.
  task automatic test_timing_extremes();
    apply_settings(1'b1, 16'd65535, 16'd65535, 16'd0, 16'd0, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    offer_request(1'b0, 1'b1);
    offer_request(1'b0, 1'b1);
    offer_request(1'b0, 1'b0);
  endtask

  task automatic test_coin_trains();
    logic [15:0] deb;
    int          phase;
    phase = 0;
    while (sent_requests < 200) begin
      deb = $urandom_range(0, 3);
      apply_settings(1'b1, deb, ((deb == 16'd0) ? 16'd1 : deb) + 16'($urandom_range(1, 8)),
                     16'($urandom_range(0, 8)),
                     ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)),
                     ($urandom_range(99) < 60) ? 3'd4 : 3'($urandom_range(0, 7)),
                     random_table());
      // first phase: no idling at all, and a long receiver hold-off so the
      // queue fills up and in_stall has to rise
      calm = (phase == 0);
      if (phase == 0) holdoff_req++;
      repeat (8) begin
        if ($urandom_range(99) < 10) offer_request(1'b1, $urandom_range(1));
        send_coin(pick_pulses());
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  // Exactly at the limit, just over it, well over it, and long enough to saturate the group counter.
  task automatic test_long_trains();
    apply_settings(1'b1, 16'd1, 16'd2, 16'd2, 16'($urandom_range(1, 65535)), 3'd4,
                   64'h4D20_1414_0A0A_0101);
    send_coin(32);
    send_coin(33);
    send_coin($urandom_range(34, 60));
    send_coin($urandom_range(260, 280));
  endtask

  // One-second timeout: a coin, then enough quiet ticks to go idle, then wake.
  task automatic test_idle_timeout();
    apply_settings(1'b1, 16'd1, 16'd3, 16'd2, 16'd1, 3'd4, RST_DENOM_TABLE);
    send_coin(1);
    repeat (1000 + $urandom_range(0, 40)) offer_request(1'b0, 1'b0);
    repeat (4) offer_request(1'b0, $urandom_range(1));
  endtask

  // Free-running requests under random settings, one phase disabled.
  task automatic test_random_noise();
    for (int phase = 0; phase < 3; phase++) begin
      apply_settings(phase != 1, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
                     16'($urandom_range(0, 6)), 16'($urandom_range(0, 65535)),
                     3'($urandom_range(0, 7)), random_table());
      repeat (50) offer_request($urandom_range(99) < 5, $urandom_range(99) < 40);
    end
  endtask

  // Longest guard: edges after the close are ignored, even once guard is 0.
  task automatic test_guard_extreme();
    apply_settings(1'b1, 16'd1, 16'd0, 16'd65535, 16'd65535, 3'd4, random_table());
    offer_request(1'b0, 1'b1);
    offer_request(1'b0, 1'b0);
    offer_request(1'b0, 1'b1);
    offer_request(1'b0, 1'b1);
    drain_results();
    write_reg(REG_GUARD, 64'd0);
    offer_request(1'b0, 1'b1);
    offer_request(1'b0, 1'b0);
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    command   = 1'b0;
    pin_edge  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_power_on();
    test_table_lookup();
    test_clear_and_disable();
    test_timing_extremes();
    test_coin_trains();
    test_long_trains();
    test_idle_timeout();
    test_random_noise();
    test_guard_extreme();

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("tb_coin_pulse_group_decoder: PASS");
    end else begin
      if (owed_results.size() != 0)
        $display("%0t %0d expected results never arrived", $time, owed_results.size());
      $display("tb_coin_pulse_group_decoder: FAIL");
    end
    $finish;
  end

endmodule
